[rtl/vlsd_pkg.sv]
// Shared types and constants for the value list with search and delete.
package vlsd_pkg;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int IN_W     = 40;  // command + value, padded to whole bytes
    localparam int OUT_W    = 16;  // status + found + count, padded to whole bytes

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SEARCH     = 3'd4,
        CMD_SEARCH_DEL = 3'd5,
        CMD_CLEAR      = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;       // latch the incoming word, clear index and result
        logic    exec;       // carry out a single-step command
        logic    res_set;    // overwrite the pending result
        status_t res_status;
        logic    res_found;
        logic    rd_en;      // read the entry at index (or index + 1)
        logic    rd_next;    // read address is index + 1
        logic    shift_wr;   // write the read entry one place towards the front
        logic    idx_inc;
        logic    count_dec;
        logic    out_load;   // move the result into the output register
    } ctrl_t;

    // Datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic empty;
        logic full;
        logic match;         // entry read last cycle equals the search value
        logic at_last;       // index points at the last valid entry
        logic out_free;      // output register can take a result this cycle
    } stat_t;

endpackage

[rtl/value_list_with_search_delete.sv]
// Top level of the double-ended value list with search and delete.
//
//  Channel  Direction  Signals                      Word
//  -------  ---------  ---------------------------  -----------------------------------
//  slave    in         s_tvalid s_tready s_tdata    command[2:0], value[34:3]
//  master   out        m_tvalid m_tready m_tdata    status[1:0], found[2], count[9:3]
//
// Each word is handled on its own. Push, pop and clear go through decode and finish; the
// result is registered in the finishing step. Search reads the single-port entry memory,
// with a read step and a compare step per entry examined from the front. Search and
// delete then moves each entry behind the match one place forward, with a read step and
// a write step per entry, and lowers the count in a last read step.
// Reset (rst_n low, asynchronous) empties the list; no clearing pass is needed.
// A finished result waits in the output register while the next word is accepted;
// the block stalls only in its finishing step if that register is still full.
module value_list_with_search_delete
    import vlsd_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // command[2:0], value[34:3], zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status[1:0], found[2], count[9:3], zero pad
);

    ctrl_t               ctl;
    stat_t               sts;
    logic [STATUS_W-1:0] res_status;
    logic                res_found;
    logic [COUNT_W-1:0]  res_count;

    // Sequencer: one word at a time, ready only when idle
    vlsd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Ring-buffer memory plus head/count, scan index and output register
    vlsd_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .in_command (s_tdata[CMD_W-1:0]),
        .in_value   (s_tdata[CMD_W+VALUE_W-1:CMD_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (res_status),
        .out_found  (res_found),
        .out_count  (res_count)
    );

    assign m_tdata = {{(OUT_W - STATUS_W - 1 - COUNT_W){1'b0}}, res_count, res_found, res_status};

`ifndef SYNTHESIS
    // One word at a time: acceptance is never followed straight away by another
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while one is in progress");

    // A result never overwrites one still waiting on the master side
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> sts.out_free)
        else $error("result loaded over a pending result");

    // Inserts are only carried out when there is room
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec && (sts.cmd == CMD_PUSH_FRONT || sts.cmd == CMD_PUSH_BACK) |-> !sts.full)
        else $error("insert into a full list");

    // Compaction only happens on a non-empty list
    a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift_wr |-> !sts.empty)
        else $error("entry moved in an empty list");
`endif

endmodule

[rtl/vlsd_ctrl.sv]
// Command sequencer for the value list: decode, scan and compaction control.
module vlsd_ctrl
    import vlsd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t sts,
    output ctrl_t ctl
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DECODE   = 7'b0000010,
        S_SCAN_RD  = 7'b0000100,
        S_SCAN_CMP = 7'b0001000,
        S_SHIFT_RD = 7'b0010000,
        S_SHIFT_WR = 7'b0100000,
        S_FINISH   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                case (sts.cmd)
                    CMD_PUSH_FRONT, CMD_PUSH_BACK:
                    begin
                        if (sts.full)
                        begin
                            ctl.res_set    = 1'b1;
                            ctl.res_status = ST_FULL;
                        end
                        else
                        begin
                            ctl.exec = 1'b1;
                        end
                    end
                    CMD_POP_FRONT, CMD_POP_BACK:
                    begin
                        if (sts.empty)
                        begin
                            ctl.res_set    = 1'b1;
                            ctl.res_status = ST_EMPTY;
                        end
                        else
                        begin
                            ctl.exec = 1'b1;
                        end
                    end
                    CMD_SEARCH, CMD_SEARCH_DEL:
                    begin
                        if (sts.empty)
                        begin
                            ctl.res_set    = 1'b1;
                            ctl.res_status = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    default:
                    begin
                        ctl.exec = 1'b1;  // clear; unused code does nothing
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                ctl.rd_en  = 1'b1;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (sts.match)
                begin
                    ctl.res_set    = 1'b1;
                    ctl.res_status = ST_OK;
                    ctl.res_found  = 1'b1;
                    state_next     = (sts.cmd == CMD_SEARCH_DEL) ? S_SHIFT_RD : S_FINISH;
                end
                else if (sts.at_last)
                begin
                    ctl.res_set    = 1'b1;
                    ctl.res_status = ST_NOTFOUND;
                    state_next     = S_FINISH;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (sts.at_last)
                begin
                    ctl.count_dec = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    ctl.rd_en   = 1'b1;
                    ctl.rd_next = 1'b1;
                    state_next  = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                ctl.shift_wr = 1'b1;
                ctl.idx_inc  = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/vlsd_dp.sv]
// Datapath: circular entry memory, head/count/index registers and result register.
module vlsd_dp
    import vlsd_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_t               ctl,
    output stat_t               sts,
    input  logic [CMD_W-1:0]    in_command,
    input  logic [VALUE_W-1:0]  in_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic                out_found,
    output logic [COUNT_W-1:0]  out_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [VALUE_W-1:0] entries_mem [DEPTH];

    cmd_t               cmd_reg,        cmd_next;
    logic [VALUE_W-1:0] value_reg,      value_next;
    logic [CW-1:0]      idx_reg,        idx_next;
    logic [AW-1:0]      head_reg,       head_next;
    logic [CW-1:0]      count_reg,      count_next;
    status_t            res_status_reg, res_status_next;
    logic               res_found_reg,  res_found_next;
    logic               out_valid_reg,  out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic               out_found_reg,  out_found_next;
    logic [COUNT_W-1:0] out_count_reg,  out_count_next;
    logic [VALUE_W-1:0] rd_data_reg;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [AW-1:0]      rd_addr;
    logic [CW-1:0]      rd_off;
    logic [AW-1:0]      head_dec;

    // Logical position to physical address, wrapping once around the ring
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                            input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(off);
        if (sum >= SW'(DEPTH))
            sum = sum - SW'(DEPTH);
        return sum[AW-1:0];
    endfunction

    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign rd_off   = ctl.rd_next ? CW'(idx_reg + CW'(1)) : idx_reg;
    assign rd_addr  = phys(head_reg, rd_off);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = phys(head_reg, idx_reg);
        wr_data = rd_data_reg;
        if (ctl.shift_wr)
        begin
            wr_en = 1'b1;
        end
        else if (ctl.exec && cmd_reg == CMD_PUSH_FRONT)
        begin
            wr_en   = 1'b1;
            wr_addr = head_dec;
            wr_data = value_reg;
        end
        else if (ctl.exec && cmd_reg == CMD_PUSH_BACK)
        begin
            wr_en   = 1'b1;
            wr_addr = phys(head_reg, count_reg);
            wr_data = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entries_mem[wr_addr] <= wr_data;
        if (ctl.rd_en)
            rd_data_reg <= entries_mem[rd_addr];
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        value_next      = value_reg;
        idx_next        = idx_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;

        if (ctl.load)
        begin
            cmd_next        = cmd_t'(in_command);
            value_next      = in_value;
            idx_next        = '0;
            res_status_next = ST_OK;
            res_found_next  = 1'b0;
        end
        if (ctl.exec)
        begin
            case (cmd_reg)
                CMD_PUSH_FRONT:
                begin
                    head_next  = head_dec;
                    count_next = count_reg + CW'(1);
                end
                CMD_PUSH_BACK:
                begin
                    count_next = count_reg + CW'(1);
                end
                CMD_POP_FRONT:
                begin
                    head_next  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
                    count_next = count_reg - CW'(1);
                end
                CMD_POP_BACK:
                begin
                    count_next = count_reg - CW'(1);
                end
                CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
        if (ctl.count_dec)
            count_next = count_reg - CW'(1);
        if (ctl.idx_inc)
            idx_next = idx_reg + CW'(1);
        if (ctl.res_set)
        begin
            res_status_next = ctl.res_status;
            res_found_next  = ctl.res_found;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;
        if (ctl.out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_found_next  = res_found_reg;
            out_count_next  = COUNT_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            cmd_reg        <= CMD_CLEAR;
            res_status_reg <= ST_OK;
            res_found_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            idx_reg        <= idx_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            cmd_reg        <= cmd_next;
            res_status_reg <= res_status_next;
            res_found_reg  <= res_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
    end

    assign sts.cmd      = cmd_reg;
    assign sts.empty    = (count_reg == '0);
    assign sts.full     = (SW'(count_reg) >= SW'(DEPTH));
    assign sts.match    = (rd_data_reg == value_reg);
    assign sts.at_last  = (SW'(idx_reg) + SW'(1) >= SW'(count_reg));
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_found  = out_found_reg;
    assign out_count  = out_count_reg;

endmodule

[dv/value_list_with_search_delete_test.sv]
// Self-checking testbench for the double-ended value list with search and delete.
module value_list_with_search_delete_test;
    import vlsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    // Code 7 is not a command; the block must leave the list alone and answer ok
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [VALUE_W-1:0] VAL_NEG_ONE = 32'hffff_ffff;
    localparam int MAX_REPORTS = 10;
    // Worst case is a search and delete across a full list
    localparam int SETTLE_CYCLES = 4 * DEPTH + 16;

    // One result word as the block returns it, laid out as on m_tdata
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               found;
        status_t            status;
    } result_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;   // command[2:0], value[34:3], zero pad
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;   // status[1:0], found[2], count[9:3], zero pad

    // Shadow copy of the list, front at index 0
    logic [VALUE_W-1:0] list_q[$];
    // Answers still owed by the block, oldest first
    result_t            pending_results[$];

    // Idling controls, changed as the run moves through its phases
    bit idle_on;
    int gap_pct;
    int stall_pct;
    int ready_hold;

    // Bookkeeping
    int words_sent;
    int results_checked;
    int mismatches;
    int peak_count;
    int status_seen[4];
    int hits_seen;

    value_list_with_search_delete #(
        .DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Applies one command to the shadow list and returns the answer the block owes.
    function automatic result_t apply_to_list(input logic [CMD_W-1:0] cmd,
                                              input logic [VALUE_W-1:0] val);
        result_t r;
        int      pos;
        r.status = ST_OK;
        r.found  = 1'b0;
        pos      = -1;
        case (cmd)
            CMD_PUSH_FRONT:
                if (list_q.size() >= DEPTH)
                    r.status = ST_FULL;
                else
                    list_q.push_front(val);
            CMD_PUSH_BACK:
                if (list_q.size() >= DEPTH)
                    r.status = ST_FULL;
                else
                    list_q.push_back(val);
            CMD_POP_FRONT:
                if (list_q.size() == 0)
                    r.status = ST_EMPTY;
                else
                    void'(list_q.pop_front());
            CMD_POP_BACK:
                if (list_q.size() == 0)
                    r.status = ST_EMPTY;
                else
                    void'(list_q.pop_back());
            CMD_SEARCH, CMD_SEARCH_DEL:
                if (list_q.size() == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    // first match nearest the front wins
                    for (int i = 0; i < list_q.size(); i++)
                    begin
                        if (pos < 0 && list_q[i] == val)
                            pos = i;
                    end
                    if (pos < 0)
                        r.status = ST_NOTFOUND;
                    else
                    begin
                        r.found = 1'b1;
                        if (cmd == CMD_SEARCH_DEL)
                            list_q.delete(pos);
                    end
                end
            CMD_CLEAR:
                list_q.delete();
            default:
                ;
        endcase
        r.count = COUNT_W'(list_q.size());
        if (list_q.size() > peak_count)
            peak_count = list_q.size();
        return r;
    endfunction

    // Value mix: mostly entries already held or a small pool (so searches hit and
    // duplicates appear), the rest fully random so every bit toggles.
    function automatic logic [VALUE_W-1:0] pick_value();
        int                 r;
        logic [VALUE_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 35 && list_q.size() > 0)
            v = list_q[$urandom_range(0, list_q.size() - 1)];
        else if (r < 65)
        begin
            v = $urandom_range(0, 8);
            v = v - 4;
        end
        else
            v = $urandom();
        return v;
    endfunction

    // Drives one word at the falling edge and waits for it to be taken.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - CMD_W - VALUE_W){1'b0}}, val, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(apply_to_list(cmd, val));
        words_sent++;
    endtask

    // Holds the sender off until every owed answer is in, then lets the block settle.
    task automatic wait_drained(input int extra);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Empty-list cases, both extreme values, hits, misses, duplicates, code 7, clear.
    task automatic test_directed();
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_BACK, VAL_NEG_ONE);
        send_word(CMD_SEARCH, '0);
        send_word(CMD_SEARCH_DEL, '0);
        send_word(CMD_PUSH_BACK, VAL_MIN);
        send_word(CMD_PUSH_FRONT, VAL_MAX);
        send_word(CMD_PUSH_BACK, '0);
        send_word(CMD_PUSH_BACK, VAL_NEG_ONE);
        send_word(CMD_PUSH_BACK, '0);
        send_word(CMD_SEARCH, VAL_MIN);
        send_word(CMD_SEARCH, 32'd1);
        send_word(CMD_SEARCH, VAL_NEG_ONE);
        // two zeros held: only the one nearer the front goes
        send_word(CMD_SEARCH_DEL, '0);
        send_word(CMD_SEARCH, '0);
        send_word(CMD_SEARCH_DEL, 32'd5);
        send_word(CMD_UNUSED, VAL_NEG_ONE);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_CLEAR, VAL_MAX);
        send_word(CMD_CLEAR, '0);
        send_word(CMD_PUSH_FRONT, 32'd1);
        // deleting the only entry leaves the list empty
        send_word(CMD_SEARCH_DEL, 32'd1);
    endtask

    // Fill to capacity, push into a full list, long searches, then drain past empty.
    task automatic test_fill_and_drain();
        send_word(CMD_CLEAR, '0);
        for (int i = 0; i < DEPTH; i++)
            send_word($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom());
        send_word(CMD_PUSH_FRONT, $urandom());
        send_word(CMD_PUSH_BACK, VAL_MIN);
        send_word(CMD_SEARCH, list_q[DEPTH - 1]);
        send_word(CMD_SEARCH, $urandom());
        send_word(CMD_SEARCH_DEL, list_q[DEPTH - 1]);
        send_word(CMD_SEARCH_DEL, list_q[0]);
        send_word(CMD_SEARCH_DEL, list_q[DEPTH / 2 - 1]);
        for (int i = 0; i < 4; i++)
            send_word(CMD_PUSH_BACK, $urandom());
        send_word(CMD_SEARCH_DEL, $urandom());
        while (list_q.size() > 0)
            send_word($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, $urandom());
        send_word(CMD_POP_BACK, '0);
    endtask

    // Random traffic; every 64 words the push bias and idling rates are re-drawn so
    // the list wanders between empty and full and some stretches run without gaps.
    task automatic test_random_mix(input int n_words);
        int                 bias_tab[5];
        int                 rate_tab[4];
        int                 push_bias;
        int                 r;
        logic [CMD_W-1:0]   cmd;
        bias_tab  = '{15, 45, 50, 55, 85};
        rate_tab  = '{0, 10, 30, 50};
        push_bias = 50;
        for (int n = 0; n < n_words; n++)
        begin
            if (n % 64 == 0)
            begin
                push_bias = bias_tab[$urandom_range(0, 4)];
                gap_pct   = rate_tab[$urandom_range(0, 3)];
                stall_pct = rate_tab[$urandom_range(0, 3)];
            end
            r = $urandom_range(0, 99);
            if (r < push_bias)
                cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 30)
                    cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
                else if (r < 60)
                    cmd = CMD_SEARCH;
                else if (r < 94)
                    cmd = CMD_SEARCH_DEL;
                else if (r < 97)
                    cmd = CMD_UNUSED;
                else
                    cmd = CMD_CLEAR;
            end
            send_word(cmd, pick_value());
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_full_rate_tail();
        idle_on = 1'b0;
        test_random_mix(150);
    endtask

    // Receiver: ready drops in bursts, at the stall rate, while idling is on.
    always @(negedge clk)
    begin
        if (idle_on && ready_hold > 0)
        begin
            ready_hold--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 99) < stall_pct)
        begin
            ready_hold = $urandom_range(1, 13) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Compares each result word taken with the oldest owed answer.
    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[STATUS_W + COUNT_W:0]);
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result word: status %0d found %0d count %0d",
                             $realtime, got.status, got.found, got.count);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                status_seen[got.status]++;
                if (got.found)
                    hits_seen++;
                if (got.status !== want.status || got.found !== want.found
                    || got.count !== want.count)
                begin
                    mismatches++;
                    // fields in order: status, found, count
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result %0d: expected %0d %0d %0d, got %0d %0d %0d",
                                 $realtime, results_checked, want.status, want.found,
                                 want.count, got.status, got.found, got.count);
                end
            end
        end
    end

    // Guard against a hung handshake.
    initial
    begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        idle_on    = 1'b1;
        gap_pct    = 25;
        stall_pct  = 25;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        wait_drained(0);
        test_fill_and_drain();
        // sender waits here until every answer is back
        wait_drained(0);
        test_random_mix(1250);
        wait_drained(0);
        test_full_rate_tail();
        wait_drained(SETTLE_CYCLES);

        $display("Sent %0d words, checked %0d results; list peaked at %0d of %0d entries.",
                 words_sent, results_checked, peak_count, DEPTH);
        $display("Statuses seen: ok %0d, empty %0d, not found %0d, full %0d; search hits %0d.",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_NOTFOUND],
                 status_seen[ST_FULL], hits_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
